[design/csg_pkg.sv]
// ----------------------------------------------------------------------------
// csg_pkg
// Shared constants, register indexes and types of the chirp and sine generator.
// ----------------------------------------------------------------------------
package csg_pkg;

   localparam int FREQ_FRAC_BITS = 16;

   localparam logic [1:0] MODE_CHIRP  = 2'd0;
   localparam logic [1:0] MODE_SINE   = 2'd1;
   localparam logic [1:0] MODE_COSINE = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [2:0] CSR_MODE       = 3'd0;
   localparam logic [2:0] CSR_AMPLITUDE  = 3'd1;
   localparam logic [2:0] CSR_START_FREQ = 3'd2;
   localparam logic [2:0] CSR_END_FREQ   = 3'd3;
   localparam logic [2:0] CSR_SWEEP_TIME = 3'd4;

   localparam logic [31:0] SWEEP_RESET  = 32'h0001_0000;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [31:0] EIGHTH_TURN  = 32'h2000_0000;
   localparam logic [63:0] INV_TWO_PI   = 64'h28BE_60DB_9391_054A;
   localparam logic signed [31:0] HALF_PI     = 32'sh6487_ED51;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sh0_26DD_3B6A;
   localparam logic [62:0] RATE_MAX = {63{1'b1}};

   localparam int CW = 34;

   typedef struct packed {
      logic        neg;
      logic [62:0] mag;
   } rate_type;

   function automatic logic signed [CW-1:0] atan_q30(input int idx);
      logic signed [CW-1:0] v;
      begin
         case (idx)
            0: v = 34'sh3243F6A8;
            1: v = 34'sh1DAC6705;
            2: v = 34'sh0FADBAFC;
            3: v = 34'sh07F56EA6;
            4: v = 34'sh03FEAB76;
            5: v = 34'sh01FFD55B;
            6: v = 34'sh00FFFAAA;
            7: v = 34'sh007FFF55;
            8: v = 34'sh003FFFEA;
            9: v = 34'sh001FFFFD;
            10: v = 34'sh000FFFFF;
            11: v = 34'sh0007FFFF;
            12: v = 34'sh0003FFFF;
            13: v = 34'sh0001FFFF;
            14: v = 34'sh0000FFFF;
            15: v = 34'sh00007FFF;
            16: v = 34'sh00003FFF;
            17: v = 34'sh00001FFF;
            18: v = 34'sh00000FFF;
            19: v = 34'sh000007FF;
            20: v = 34'sh000003FF;
            21: v = 34'sh000001FF;
            22: v = 34'sh000000FF;
            23: v = 34'sh0000007F;
            default: v = '0;
         endcase
         return v;
      end
   endfunction

endpackage

[design/csg_sweep_div.sv]
// ----------------------------------------------------------------------------
// csg_sweep_div
// Bit-serial restoring divider for the chirp sweep rate (end - start) / sweep.
// ----------------------------------------------------------------------------
module csg_sweep_div import csg_pkg::*; #(
   parameter int TIME_FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        kick,
   input  logic [31:0] start_freq,
   input  logic [31:0] end_freq,
   input  logic [31:0] sweep_time,
   output rate_type    rate,
   output logic        running
);

   localparam int Extra = 32 - FREQ_FRAC_BITS + TIME_FRAC_BITS;
   localparam int Total = 32 + Extra;
   localparam int CntW  = $clog2(Total + 1);

   logic            run_ff, run_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [Total-1:0] dvd_ff, dvd_in;
   logic [31:0]     r_ff, r_in;
   logic [63:0]     q_ff, q_in;
   logic            sat_ff, sat_in;
   logic            neg_ff, neg_in;
   rate_type        rate_ff, rate_in;

   logic [32:0] diff;
   logic [31:0] mag_n;
   logic [32:0] r_sh;
   logic        fits;
   logic [32:0] r_sub;

   always_comb begin
      diff  = {1'b0, end_freq} - {1'b0, start_freq};
      mag_n = diff[32] ? 32'(-diff) : diff[31:0];
      r_sh  = {r_ff, dvd_ff[Total-1]};
      fits  = r_sh >= {1'b0, sweep_time};
      r_sub = r_sh - {1'b0, sweep_time};

      run_in  = run_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      r_in    = r_ff;
      q_in    = q_ff;
      sat_in  = sat_ff;
      neg_in  = neg_ff;
      rate_in = rate_ff;
      if (kick) begin
         run_in = 1'b1;
         cnt_in = CntW'(Total);
         dvd_in = {mag_n, {Extra{1'b0}}};
         r_in   = '0;
         q_in   = '0;
         sat_in = 1'b0;
         neg_in = diff[32];
      end else if (run_ff) begin
         dvd_in = {dvd_ff[Total-2:0], 1'b0};
         r_in   = fits ? r_sub[31:0] : r_sh[31:0];
         q_in   = {q_ff[62:0], fits};
         sat_in = sat_ff | (q_ff[63:62] != 2'b00);
         cnt_in = cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) begin
            run_in      = 1'b0;
            rate_in.neg = neg_ff;
            if (sweep_time == '0)
               rate_in.mag = '0;
            else if (sat_in || q_in[63])
               rate_in.mag = RATE_MAX;
            else
               rate_in.mag = q_in[62:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         cnt_ff  <= '0;
         rate_ff <= '0;
      end else begin
         run_ff  <= run_in;
         cnt_ff  <= cnt_in;
         rate_ff <= rate_in;
      end
      dvd_ff <= dvd_in;
      r_ff   <= r_in;
      q_ff   <= q_in;
      sat_ff <= sat_in;
      neg_ff <= neg_in;
   end

   assign rate    = rate_ff;
   assign running = run_ff;

endmodule

[design/csg_phase.sv]
// ----------------------------------------------------------------------------
// csg_phase
// Four-stage phase pipeline: time products, partial products, sum, turn phase.
// ----------------------------------------------------------------------------
module csg_phase import csg_pkg::*; #(
   parameter int TIME_FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [31:0] time_now,
   input  logic [1:0]  mode,
   input  logic [31:0] start_freq,
   input  rate_type    rate,
   output logic        phase_valid,
   output logic [31:0] phase
);

   localparam int W       = 2 * TIME_FRAC_BITS + 33;
   localparam int TonePos = 32 + FREQ_FRAC_BITS + TIME_FRAC_BITS;

   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic [63:0] tsq_ff, tsq_in, lin_ff, lin_in;
   logic [63:0] pp00_ff, pp01_ff, pp10_ff, pp11_ff;
   logic [63:0] pp00_in, pp01_in, pp10_in, pp11_in;
   logic [31:0] lt2_ff, lt2_in, lt3_ff;
   logic [127:0] prod_ff, prod_in;
   logic [31:0] phase_ff, phase_in;

   logic [63:0] op_a, op_b;
   logic [63+FREQ_FRAC_BITS:0] lin_ext;
   logic [33:0] mid;
   logic [63:0] hi;
   logic [W-1:0] low, low_c;
   logic [31:0] tone_ph;

   always_comb begin
      tsq_in = 64'(time_now) * 64'(time_now);
      lin_in = 64'(start_freq) * 64'(time_now);

      op_a    = (mode == MODE_CHIRP) ? {1'b0, rate.mag} : lin_ff;
      op_b    = (mode == MODE_CHIRP) ? tsq_ff : INV_TWO_PI;
      pp00_in = 64'(op_a[31:0]) * 64'(op_b[31:0]);
      pp01_in = 64'(op_a[31:0]) * 64'(op_b[63:32]);
      pp10_in = 64'(op_a[63:32]) * 64'(op_b[31:0]);
      pp11_in = 64'(op_a[63:32]) * 64'(op_b[63:32]);
      lin_ext = {lin_ff, {FREQ_FRAC_BITS{1'b0}}};
      lt2_in  = lin_ext[TIME_FRAC_BITS+31:TIME_FRAC_BITS];

      mid     = 34'(pp00_ff[63:32]) + 34'(pp01_ff[31:0]) + 34'(pp10_ff[31:0]);
      hi      = pp11_ff + 64'(pp01_ff[63:32]) + 64'(pp10_ff[63:32]) + 64'(mid[33:32]);
      prod_in = {hi, mid[31:0], pp00_ff[31:0]};

      low     = prod_ff[W-1:0];
      low_c   = rate.neg ? (~low) + W'(1) : low;
      tone_ph = prod_ff[TonePos+31:TonePos];
      if (mode == MODE_CHIRP)
         phase_in = low_c[W-1:W-32] + lt3_ff;
      else if (mode == MODE_COSINE)
         phase_in = tone_ph + QUARTER_TURN;
      else
         phase_in = tone_ph;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      tsq_ff   <= tsq_in;
      lin_ff   <= lin_in;
      pp00_ff  <= pp00_in;
      pp01_ff  <= pp01_in;
      pp10_ff  <= pp10_in;
      pp11_ff  <= pp11_in;
      lt2_ff   <= lt2_in;
      lt3_ff   <= lt2_ff;
      prod_ff  <= prod_in;
      phase_ff <= phase_in;
   end

   assign phase_valid = v4_ff;
   assign phase       = phase_ff;

endmodule

[design/csg_cordic.sv]
// ----------------------------------------------------------------------------
// csg_cordic
// Quadrant reduction and pipelined CORDIC rotation, one register per iteration.
// ----------------------------------------------------------------------------
module csg_cordic import csg_pkg::*; #(
   parameter int SINE_STAGES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 phase_valid,
   input  logic [31:0]          phase,
   output logic                 sine_valid,
   output logic signed [CW-1:0] sine
);

   logic        fv_ff;
   logic [1:0]  fq_ff;
   logic signed [63:0] fprod_ff, fprod_in;
   logic [31:0] shifted;
   logic signed [31:0] resid;

   logic signed [CW-1:0] xi [0:SINE_STAGES];
   logic signed [CW-1:0] yi [0:SINE_STAGES];
   logic signed [CW-1:0] zi [0:SINE_STAGES];
   logic [1:0]           qi [0:SINE_STAGES];
   logic                 vi [0:SINE_STAGES];

   always_comb begin
      shifted  = phase + EIGHTH_TURN;
      resid    = $signed({2'b00, shifted[29:0]}) - $signed(EIGHTH_TURN);
      fprod_in = 64'(resid) * 64'(HALF_PI);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 1'b0;
      end else begin
         fv_ff <= phase_valid;
      end
      fq_ff    <= shifted[31:30];
      fprod_ff <= fprod_in;
   end

   assign xi[0] = CORDIC_GAIN;
   assign yi[0] = '0;
   assign zi[0] = fprod_ff[63:30];
   assign qi[0] = fq_ff;
   assign vi[0] = fv_ff;

   for (genvar k = 0; k < SINE_STAGES; k++) begin : g_stage
      logic signed [CW-1:0] x_ff, y_ff, z_ff, x_in, y_in, z_in;
      logic [1:0]           q_ff;
      logic                 v_ff;

      always_comb begin
         if (zi[k] >= 0) begin
            x_in = xi[k] - (yi[k] >>> k);
            y_in = yi[k] + (xi[k] >>> k);
            z_in = zi[k] - atan_q30(k);
         end else begin
            x_in = xi[k] + (yi[k] >>> k);
            y_in = yi[k] - (xi[k] >>> k);
            z_in = zi[k] + atan_q30(k);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else begin
            v_ff <= vi[k];
         end
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
         q_ff <= qi[k];
      end

      assign xi[k+1] = x_ff;
      assign yi[k+1] = y_ff;
      assign zi[k+1] = z_ff;
      assign qi[k+1] = q_ff;
      assign vi[k+1] = v_ff;
   end

   always_comb begin
      unique case (qi[SINE_STAGES])
         2'd0: sine = yi[SINE_STAGES];
         2'd1: sine = xi[SINE_STAGES];
         2'd2: sine = -yi[SINE_STAGES];
         default: sine = -xi[SINE_STAGES];
      endcase
   end

   assign sine_valid = vi[SINE_STAGES];

endmodule

[design/chirp_and_sinusoid_generator.sv]
// ----------------------------------------------------------------------------
// chirp_and_sinusoid_generator
// Linear chirp, sine and cosine sample source with amplitude scaling.
// ----------------------------------------------------------------------------
// throughput: one transaction per cycle while busy is low, set by the fully pipelined datapath
// busy goes high after a write to a frequency or sweep register and stays high
// while the serial divider recomputes the sweep rate
// reset clears the registers to their defaults; no clearing pass is needed
module chirp_and_sinusoid_generator import csg_pkg::*; #(
   parameter int SINE_STAGES    = 16,
   parameter int TIME_FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [31:0]        req_time_now,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_sample_out,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   logic [1:0]         mode_ff;
   logic signed [15:0] amp_ff;
   logic [31:0]        f0_ff, f1_ff, sweep_ff;
   logic               kick_ff, kick_in;
   logic               running;
   rate_type           rate;
   logic               accept;
   logic               ph_valid;
   logic [31:0]        phase;
   logic               sine_valid;
   logic signed [CW-1:0] sine;
   logic               av_ff;
   logic signed [49:0] aprod_ff, aprod_in;
   logic signed [49:0] rnd;
   logic signed [19:0] scaled;
   logic               rsp_valid_ff;
   logic signed [15:0] rsp_sample_out_ff, rsp_sample_out_in;

   assign kick_in = csr_we && (csr_index == CSR_START_FREQ || csr_index == CSR_END_FREQ ||
                               csr_index == CSR_SWEEP_TIME);
   assign busy    = kick_ff | running;
   assign accept  = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_CHIRP;
         amp_ff   <= '0;
         f0_ff    <= '0;
         f1_ff    <= '0;
         sweep_ff <= SWEEP_RESET;
         kick_ff  <= 1'b0;
      end else begin
         kick_ff <= kick_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_MODE:       mode_ff  <= csr_wdata[1:0];
               CSR_AMPLITUDE:  amp_ff   <= csr_wdata[15:0];
               CSR_START_FREQ: f0_ff    <= csr_wdata;
               CSR_END_FREQ:   f1_ff    <= csr_wdata;
               CSR_SWEEP_TIME: sweep_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   csg_sweep_div #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_div (
      .clock      (clock),
      .reset      (reset),
      .kick       (kick_ff),
      .start_freq (f0_ff),
      .end_freq   (f1_ff),
      .sweep_time (sweep_ff),
      .rate       (rate),
      .running    (running)
   );

   csg_phase #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_phase (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (accept),
      .time_now    (req_time_now),
      .mode        (mode_ff),
      .start_freq  (f0_ff),
      .rate        (rate),
      .phase_valid (ph_valid),
      .phase       (phase)
   );

   csg_cordic #(.SINE_STAGES(SINE_STAGES)) u_cordic (
      .clock       (clock),
      .reset       (reset),
      .phase_valid (ph_valid),
      .phase       (phase),
      .sine_valid  (sine_valid),
      .sine        (sine)
   );

   always_comb begin
      aprod_in = 50'(amp_ff) * 50'(sine);
      rnd      = aprod_ff + 50'sd536870912;
      scaled   = rnd[49:30];
      if (mode_ff != MODE_CHIRP && mode_ff != MODE_SINE && mode_ff != MODE_COSINE)
         rsp_sample_out_in = '0;
      else if (scaled > 20'sd32767)
         rsp_sample_out_in = 16'sh7FFF;
      else if (scaled < -20'sd32768)
         rsp_sample_out_in = 16'sh8000;
      else
         rsp_sample_out_in = scaled[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         av_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         av_ff        <= sine_valid;
         rsp_valid_ff <= av_ff;
      end
      aprod_ff          <= aprod_in;
      rsp_sample_out_ff <= rsp_sample_out_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;

`ifndef NO_ASSERTIONS
   a_kick_busy: assert property (@(posedge clock) disable iff (reset)
      kick_in |=> busy)
      else $error("sweep register write did not raise busy");

   a_unused_mode_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(mode_ff) == MODE_UNUSED |-> rsp_sample_out == 16'sd0)
      else $error("unused mode produced a nonzero sample");

   a_valid_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(av_ff))
      else $error("result strobe without a scaled sample behind it");
`endif

endmodule
